// ===== hdl/iamfc_pkg.sv =====
// ----------------------------------------------------------------------------
// iamfc_pkg
// Types and constants for the IPv4 AH mutable field clearing block.
// ----------------------------------------------------------------------------
package iamfc_pkg;

	// option type codes
	localparam logic [7:0] OPT_END     = 8'd0;
	localparam logic [7:0] OPT_NOP     = 8'd1;
	localparam logic [7:0] OPT_SEC     = 8'd130;
	localparam logic [7:0] OPT_XSEC    = 8'd133;
	localparam logic [7:0] OPT_CSEC    = 8'd134;
	localparam logic [7:0] OPT_RTALERT = 8'd148;
	localparam logic [7:0] OPT_MDEST   = 8'd149;

	// fixed header layout
	localparam logic [5:0] BASE_HDR   = 6'd20;
	localparam logic [3:0] IHL_MIN    = 4'd5;
	localparam logic [7:0] OPT_LEN_MIN = 8'd2;
	localparam logic [5:0] POS_TOS    = 6'd1;
	localparam logic [5:0] POS_FRAG_H = 6'd6;
	localparam logic [5:0] POS_FRAG_L = 6'd7;
	localparam logic [5:0] POS_TTL    = 6'd8;
	localparam logic [5:0] POS_CSUM_H = 6'd10;
	localparam logic [5:0] POS_CSUM_L = 6'd11;

	// option walker phase
	typedef enum logic [3:0] {
		PH_TYPE = 4'b0001,
		PH_LEN  = 4'b0010,
		PH_BODY = 4'b0100,
		PH_DONE = 4'b1000
	} opt_phase_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       first_byte;
	} in_item_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       cleared;
		logic       header_byte;
		logic       malformed;
	} out_item_t;

	// options that AH keeps in the integrity check
	function automatic logic kept_option(input logic [7:0] t);
		return (t == OPT_SEC) || (t == OPT_XSEC) || (t == OPT_CSEC) ||
		       (t == OPT_RTALERT) || (t == OPT_MDEST);
	endfunction

endpackage

// ===== hdl/iamfc_stream_if.sv =====
// ----------------------------------------------------------------------------
// iamfc_stream_if
// Valid/ready stream channel carrying one payload beat per handshake.
// ----------------------------------------------------------------------------
interface iamfc_stream_if #(
	parameter type payload_t = logic [7:0]
);
	logic     valid;
	logic     ready;
	payload_t payload;

	modport source (output valid, output payload, input ready);
	modport sink   (input valid, input payload, output ready);
endinterface

// ===== hdl/ipv4_ah_mutable_field_clear.sv =====
// ----------------------------------------------------------------------------
// ipv4_ah_mutable_field_clear
// Zeroes the IPv4 header fields and options that AH treats as mutable.
// ----------------------------------------------------------------------------
// Takes an IPv4 packet one byte per beat on rx, header first, with first_byte
// marking the version/IHL byte, and returns one beat per byte on tx. Type of
// service, flags/fragment offset, TTL and the header checksum are zeroed, as
// is every option other than end, NOP, security, extended security,
// commercial security, router alert and multi-destination. Bytes past the
// header pass unchanged. The block sustains one byte per cycle while tx is
// ready; each byte goes through the input register, then the result
// register, with the per-byte parse state update between the two. malformed
// flags IHL below 5, an option type with no room for its length, or a bad
// option length at the byte where it shows up.
module ipv4_ah_mutable_field_clear (
	input  logic                           clk,
	input  logic                           arst_n,
	iamfc_stream_if.sink                   rx,
	iamfc_stream_if.source                 tx
);
	import iamfc_pkg::*;

	// pipeline control
	logic       v_s1;
	in_item_t   in_s1;
	logic       v_q;
	out_item_t  res_q;
	logic       adv;

	assign adv      = v_s1 && (!v_q || tx.ready);
	assign rx.ready = !v_s1 || adv;

	// parse state
	logic [5:0] pos_q, pos_n;
	logic [5:0] hdr_len_q, hdr_len_n;
	opt_phase_t phase_q, phase_n;
	logic [7:0] left_q, left_n;
	logic       mut_q, mut_n;
	logic       active_q, active_n;

	logic       clr, hdr, bad;
	logic [7:0] b;
	logic [3:0] ihl;
	logic [8:0] opt_end;

	assign b       = in_s1.data_byte;
	assign ihl     = b[3:0];
	assign opt_end = ({3'b000, pos_q} - 9'd1) + {1'b0, b};

	// per-byte parse step
	always_comb begin
		pos_n     = pos_q;
		hdr_len_n = hdr_len_q;
		phase_n   = phase_q;
		left_n    = left_q;
		mut_n     = mut_q;
		active_n  = active_q;
		clr       = 1'b0;
		hdr       = 1'b0;
		bad       = 1'b0;
		priority if (in_s1.first_byte) begin
			hdr_len_n = {ihl, 2'b00};
			pos_n     = 6'd1;
			phase_n   = PH_TYPE;
			left_n    = 8'd0;
			mut_n     = 1'b0;
			hdr       = 1'b1;
			bad       = (ihl < IHL_MIN);
			active_n  = (ihl >= IHL_MIN);
		end else if (active_q && (pos_q >= hdr_len_q)) begin
			active_n = 1'b0;
		end else if (active_q) begin
			hdr = 1'b1;
			if (pos_q < BASE_HDR) begin
				clr = (pos_q == POS_TOS) || (pos_q == POS_FRAG_H) ||
				      (pos_q == POS_FRAG_L) || (pos_q == POS_TTL) ||
				      (pos_q == POS_CSUM_H) || (pos_q == POS_CSUM_L);
			end else begin
				unique case (phase_q)
					PH_TYPE: begin
						if (b == OPT_END) begin
							phase_n = PH_DONE;
						end else if (b != OPT_NOP) begin
							mut_n = !kept_option(b);
							clr   = !kept_option(b);
							// no room left for the length byte
							if (({1'b0, pos_q} + 7'd1) >= {1'b0, hdr_len_q}) begin
								bad     = 1'b1;
								phase_n = PH_DONE;
							end else begin
								phase_n = PH_LEN;
							end
						end
					end
					PH_LEN: begin
						clr = mut_q;
						if ((b < OPT_LEN_MIN) || (opt_end > {3'b000, hdr_len_q})) begin
							bad     = 1'b1;
							phase_n = PH_DONE;
						end else if (b == OPT_LEN_MIN) begin
							phase_n = PH_TYPE;
						end else begin
							left_n  = b - OPT_LEN_MIN;
							phase_n = PH_BODY;
						end
					end
					PH_BODY: begin
						clr = mut_q;
						if (left_q <= 8'd1) begin
							left_n  = 8'd0;
							phase_n = PH_TYPE;
						end else begin
							left_n = left_q - 8'd1;
						end
					end
					PH_DONE: begin
					end
					default: begin
						phase_n = PH_DONE;
					end
				endcase
			end
			pos_n = pos_q + 6'd1;
		end else begin
			// no packet open: byte passes unchanged
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (rx.ready) begin
			v_s1 <= rx.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rx.ready && rx.valid) begin
			in_s1 <= rx.payload;
		end
	end

	// parse state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q     <= 6'd0;
			hdr_len_q <= 6'd0;
			phase_q   <= PH_TYPE;
			left_q    <= 8'd0;
			mut_q     <= 1'b0;
			active_q  <= 1'b0;
		end else if (adv) begin
			pos_q     <= pos_n;
			hdr_len_q <= hdr_len_n;
			phase_q   <= phase_n;
			left_q    <= left_n;
			mut_q     <= mut_n;
			active_q  <= active_n;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= 1'b0;
		end else if (!v_q || tx.ready) begin
			v_q <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			res_q.out_byte    <= clr ? 8'd0 : b;
			res_q.cleared     <= clr;
			res_q.header_byte <= hdr;
			res_q.malformed   <= bad;
		end
	end

	assign tx.valid   = v_q;
	assign tx.payload = res_q;

	// checks
	a_clr_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(v_q && res_q.cleared) |-> (res_q.out_byte == 8'd0))
		else $error("cleared beat carries nonzero byte");

	a_clr_hdr: assert property (@(posedge clk) disable iff (!arst_n)
		(v_q && (res_q.cleared || res_q.malformed)) |-> res_q.header_byte)
		else $error("cleared or malformed beat outside header");

	a_empty_ready: assert property (@(posedge clk) disable iff (!arst_n)
		(!v_s1 || !v_q) |-> rx.ready)
		else $error("input stalled with a free pipeline slot");

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(v_q && !tx.ready) |=> ($stable(res_q) && !$changed(pos_q)))
		else $error("result or parse state moved during stall");

endmodule
